// ===== hw/rtl/lbmsv_pkg.sv =====
package lbmsv_pkg;

  localparam int DW = 32;
  localparam int FRAC = 24;

  typedef logic signed [DW-1:0] word_t;
  typedef logic signed [DW+7:0] wide_t;

  localparam word_t WMAX = 32'sh7FFF_FFFF;
  localparam word_t WMIN = 32'sh8000_0000;
  localparam word_t ONE = 32'sh0100_0000;
  localparam wide_t WMAX_X = 40'sd2147483647;
  localparam wide_t WMIN_X = -40'sd2147483648;

  // pipeline depths
  localparam int DIV_LAT = 33;
  localparam int SQRT_LAT = 29;
  localparam int PIPE_DEPTH = 112;

  // ceil(2^34 / 6): exact unsigned 32-bit divide by 6 with a 34-bit shift
  localparam logic [31:0] RECIP6 = 32'hAAAA_AAAB;

  localparam logic [2:0] REG_SHIFT_MODE = 3'd0;
  localparam logic [2:0] REG_QUAD_COEF = 3'd1;
  localparam logic [2:0] REG_LIN_COEF = 3'd2;
  localparam logic [2:0] REG_WEIGHT_REST = 3'd3;
  localparam logic [2:0] REG_WEIGHT_AXIS = 3'd4;
  localparam logic [2:0] REG_WEIGHT_DIAG = 3'd5;
  localparam logic [2:0] REG_RELAX_RATE = 3'd6;
  localparam logic [2:0] REG_SMAG_CONST = 3'd7;

  function automatic word_t sat_wide(wide_t v);
    if (v > WMAX_X) return WMAX;
    if (v < WMIN_X) return WMIN;
    return word_t'(v[DW-1:0]);
  endfunction

  function automatic word_t qadd(word_t a, word_t b);
    return sat_wide(wide_t'(a) + wide_t'(b));
  endfunction

  function automatic word_t qsub(word_t a, word_t b);
    return sat_wide(wide_t'(a) - wide_t'(b));
  endfunction

  function automatic logic [DW-1:0] mag(word_t a);
    return a[DW-1] ? DW'(-a) : DW'(a);
  endfunction

  function automatic word_t from_mag(logic [DW+7:0] m, logic neg);
    if (neg) begin
      if (m >= 40'h80_0000_0000 >> 8) return WMIN;
      return word_t'(-m[DW-1:0]);
    end
    if (m > 40'h00_7FFF_FFFF) return WMAX;
    return word_t'(m[DW-1:0]);
  endfunction

  // Q8.24 product, magnitude truncated, saturated
  function automatic word_t qmul(word_t a, word_t b);
    logic [2*DW-1:0] p;
    p = (2*DW)'(mag(a)) * (2*DW)'(mag(b));
    return from_mag(p[2*DW-1:FRAC], a[DW-1] ^ b[DW-1]);
  endfunction

  function automatic word_t mul2(word_t a);
    return sat_wide(wide_t'(a) <<< 1);
  endfunction

  function automatic word_t mul3(word_t a);
    return sat_wide(wide_t'(a) + (wide_t'(a) <<< 1));
  endfunction

  function automatic word_t mul18(word_t a);
    return sat_wide((wide_t'(a) <<< 4) + (wide_t'(a) <<< 1));
  endfunction

endpackage

// ===== hw/rtl/lbmsv_if.sv =====
interface lbmsv_pop_if;
  logic valid;
  logic ready;
  lbmsv_pkg::word_t pop_se;
  lbmsv_pkg::word_t pop_ne;
  lbmsv_pkg::word_t pop_e;
  lbmsv_pkg::word_t pop_n;
  lbmsv_pkg::word_t pop_sw;
  lbmsv_pkg::word_t pop_nw;
  lbmsv_pkg::word_t pop_w;
  lbmsv_pkg::word_t pop_s;
  lbmsv_pkg::word_t pop_rest;

  modport source(output valid, pop_se, pop_ne, pop_e, pop_n, pop_sw, pop_nw, pop_w,
                 pop_s, pop_rest, input ready);
  modport sink(input valid, pop_se, pop_ne, pop_e, pop_n, pop_sw, pop_nw, pop_w,
               pop_s, pop_rest, output ready);
endinterface

interface lbmsv_visc_if;
  logic valid;
  logic ready;
  lbmsv_pkg::word_t viscosity;

  modport source(output valid, viscosity, input ready);
  modport sink(input valid, viscosity, output ready);
endinterface

// ===== hw/rtl/lbmsv_div.sv =====
module lbmsv_div (
  input  logic             clk,
  input  logic             en,
  input  lbmsv_pkg::word_t num,
  input  lbmsv_pkg::word_t den,
  output lbmsv_pkg::word_t quo
);

  // quotient below 2^31 once the saturation check passes: 31 restoring steps
  localparam int QB = 31;
  localparam int LB = 7 + lbmsv_pkg::FRAC;

  logic [31:0] rem [QB+1];
  logic [LB-1:0] low [QB+1];
  logic [QB-1:0] quot [QB+1];
  logic [31:0] dmag [QB+1];
  logic neg [QB+1];
  logic fix [QB+1];
  lbmsv_pkg::word_t fval [QB+1];

  logic [31:0] nm;
  logic [31:0] dm;
  logic dz;
  logic ovf;

  assign nm = lbmsv_pkg::mag(num);
  assign dm = lbmsv_pkg::mag(den);
  assign dz = (den == '0);
  assign ovf = ({7'b0, nm} >= {dm, 7'b0});

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {7'b0, nm[31:7]};
      low[0] <= {nm[6:0], {lbmsv_pkg::FRAC{1'b0}}};
      quot[0] <= '0;
      dmag[0] <= dm;
      neg[0] <= num[31] ^ den[31];
      fix[0] <= dz | ovf;
      if (dz) begin
        if (num == '0) fval[0] <= '0;
        else fval[0] <= num[31] ? lbmsv_pkg::WMIN : lbmsv_pkg::WMAX;
      end else begin
        fval[0] <= (num[31] ^ den[31]) ? lbmsv_pkg::WMIN : lbmsv_pkg::WMAX;
      end
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [32:0] rr;
    logic ge;
    assign rr = {rem[k-1], low[k-1][LB-1]};
    assign ge = (rr >= {1'b0, dmag[k-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? 32'(rr - {1'b0, dmag[k-1]}) : rr[31:0];
        low[k] <= {low[k-1][LB-2:0], 1'b0};
        quot[k] <= {quot[k-1][QB-2:0], ge};
        dmag[k] <= dmag[k-1];
        neg[k] <= neg[k-1];
        fix[k] <= fix[k-1];
        fval[k] <= fval[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fix[QB]) quo <= fval[QB];
      else if (neg[QB]) quo <= -lbmsv_pkg::word_t'({1'b0, quot[QB]});
      else quo <= lbmsv_pkg::word_t'({1'b0, quot[QB]});
    end
  end

endmodule

// ===== hw/rtl/lbmsv_sqrt.sv =====
module lbmsv_sqrt (
  input  logic             clk,
  input  logic             en,
  input  lbmsv_pkg::word_t arg,
  output lbmsv_pkg::word_t root
);

  // floor(sqrt(arg * 2^24)), arg below 2^31: 56-bit radicand, 28 root bits
  localparam int RB = 28;
  localparam int NB = 2 * RB;

  logic [31:0] rem [RB+1];
  logic [RB-1:0] rt [RB+1];
  logic [NB-1:0] nn [RB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      rt[0] <= '0;
      // non-positive argument gives a zero root
      nn[0] <= (arg > 0) ? {1'b0, arg[30:0], {lbmsv_pkg::FRAC{1'b0}}} : '0;
    end
  end

  for (genvar k = 1; k <= RB; k++) begin : g_step
    logic [31:0] r2;
    logic [31:0] tr;
    logic ge;
    assign r2 = {rem[k-1][29:0], nn[k-1][NB-1:NB-2]};
    assign tr = {2'b0, rt[k-1], 2'b01};
    assign ge = (r2 >= tr);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? (r2 - tr) : r2;
        rt[k] <= {rt[k-1][RB-2:0], ge};
        nn[k] <= {nn[k-1][NB-3:0], 2'b00};
      end
    end
  end

  assign root = lbmsv_pkg::word_t'({4'b0, rt[RB]});

endmodule

// ===== hw/rtl/lbm_smagorinsky_viscosity_core.sv =====
// Throughput: one cell per cycle; four 31-step dividers and two 28-step
// square-root units are fully pipelined, one quotient/root bit per stage.
// An output stall freezes the whole pipeline in place.
// Reset (rst, synchronous) empties the pipeline and restores the register defaults.
module lbm_smagorinsky_viscosity_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [2:0]        cfg_addr,
  input  logic [30:0]       cfg_wdata,
  lbmsv_pop_if.sink         pop_ch,
  lbmsv_visc_if.source      visc_ch
);

  localparam int DL = lbmsv_pkg::DIV_LAT;
  localparam int SL = lbmsv_pkg::SQRT_LAT;
  localparam int PD = lbmsv_pkg::PIPE_DEPTH;

  // configuration
  logic shift_mode;
  logic [30:0] quad_coef;
  logic [30:0] lin_coef;
  logic [24:0] weight_axis;
  logic [24:0] weight_diag;
  logic [25:0] relax_rate;
  logic [24:0] smag_const;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_mode <= 1'b1;
      quad_coef <= 31'd75497472;
      lin_coef <= 31'd50331648;
      weight_axis <= 25'd1864135;
      weight_diag <= 25'd466034;
      relax_rate <= 26'd16777216;
      smag_const <= 25'd2516582;
    end else if (cfg_wen) begin
      case (cfg_addr)
        lbmsv_pkg::REG_SHIFT_MODE:  shift_mode <= cfg_wdata[0];
        lbmsv_pkg::REG_QUAD_COEF:   quad_coef <= cfg_wdata;
        lbmsv_pkg::REG_LIN_COEF:    lin_coef <= cfg_wdata;
        lbmsv_pkg::REG_WEIGHT_REST: ; // rest equilibrium never enters the flux tensor
        lbmsv_pkg::REG_WEIGHT_AXIS: weight_axis <= cfg_wdata[24:0];
        lbmsv_pkg::REG_WEIGHT_DIAG: weight_diag <= cfg_wdata[24:0];
        lbmsv_pkg::REG_RELAX_RATE:  relax_rate <= cfg_wdata[25:0];
        lbmsv_pkg::REG_SMAG_CONST:  smag_const <= cfg_wdata[24:0];
        default: ;
      endcase
    end
  end

  lbmsv_pkg::word_t qc, lc, wa, wd, om, cs, c0;
  assign qc = lbmsv_pkg::word_t'({1'b0, quad_coef});
  assign lc = lbmsv_pkg::word_t'({1'b0, lin_coef});
  assign wa = lbmsv_pkg::word_t'({7'b0, weight_axis});
  assign wd = lbmsv_pkg::word_t'({7'b0, weight_diag});
  assign om = lbmsv_pkg::word_t'({6'b0, relax_rate});
  assign cs = lbmsv_pkg::word_t'({7'b0, smag_const});
  assign c0 = shift_mode ? '0 : lbmsv_pkg::ONE;

  // pipeline control
  logic en;
  logic [PD-1:0] vld;

  assign en = !vld[PD-1] || visc_ch.ready;
  assign pop_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[PD-2:0], pop_ch.valid};
  end

  // population order: se, ne, e, n, sw, nw, w, s, rest
  lbmsv_pkg::word_t xin [9];
  assign xin[0] = pop_ch.pop_se;
  assign xin[1] = pop_ch.pop_ne;
  assign xin[2] = pop_ch.pop_e;
  assign xin[3] = pop_ch.pop_n;
  assign xin[4] = pop_ch.pop_sw;
  assign xin[5] = pop_ch.pop_nw;
  assign xin[6] = pop_ch.pop_w;
  assign xin[7] = pop_ch.pop_s;
  assign xin[8] = pop_ch.pop_rest;

  // stages 1..3: density and momentum
  lbmsv_pkg::word_t s1_x [9];
  lbmsv_pkg::word_t s1_a, s1_b, s1_c, s1_d, s1_mx, s1_my;
  lbmsv_pkg::word_t s2_x [9];
  lbmsv_pkg::word_t s2_rho, s2_mx, s2_my;
  lbmsv_pkg::word_t s3_x [8];
  lbmsv_pkg::word_t s3_rho, s3_mx, s3_my;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x <= xin;
      s1_a <= lbmsv_pkg::qadd(xin[0], xin[1]);
      s1_b <= lbmsv_pkg::qadd(xin[2], xin[3]);
      s1_c <= lbmsv_pkg::qadd(xin[4], xin[5]);
      s1_d <= lbmsv_pkg::qadd(xin[6], xin[7]);
      s1_mx <= lbmsv_pkg::qadd(lbmsv_pkg::qadd(xin[0], xin[1]), xin[2]);
      s1_my <= lbmsv_pkg::qadd(lbmsv_pkg::qadd(xin[1], xin[3]), xin[5]);

      s2_x <= s1_x;
      s2_rho <= lbmsv_pkg::qadd(lbmsv_pkg::qadd(s1_a, s1_b), lbmsv_pkg::qadd(s1_c, s1_d));
      s2_mx <= lbmsv_pkg::qsub(lbmsv_pkg::qsub(s1_mx, s1_x[4]), s1_x[5]);
      s2_my <= lbmsv_pkg::qsub(lbmsv_pkg::qsub(s1_my, s1_x[0]), s1_x[4]);

      for (int j = 0; j < 8; j++) s3_x[j] <= s2_x[j];
      s3_rho <= lbmsv_pkg::qadd(lbmsv_pkg::qadd(s2_rho, s2_x[8]),
                                shift_mode ? lbmsv_pkg::ONE : '0);
      s3_mx <= lbmsv_pkg::qsub(s2_mx, s2_x[6]);
      s3_my <= lbmsv_pkg::qsub(s2_my, s2_x[7]);
    end
  end

  // dividers: velocity and the two relaxation terms
  lbmsv_pkg::word_t vx, vy, inv, half;

  lbmsv_div u_div_vx (.clk(clk), .en(en), .num(s3_mx), .den(s3_rho), .quo(vx));
  lbmsv_div u_div_vy (.clk(clk), .en(en), .num(s3_my), .den(s3_rho), .quo(vy));
  lbmsv_div u_div_inv (.clk(clk), .en(en), .num(lbmsv_pkg::ONE), .den(om), .quo(inv));
  lbmsv_div u_div_half (.clk(clk), .en(en), .num(lbmsv_pkg::ONE),
                        .den(lbmsv_pkg::mul2(om)), .quo(half));

  lbmsv_pkg::word_t dpop [DL][8];
  lbmsv_pkg::word_t drho [DL];

  always_ff @(posedge clk) begin
    if (en) begin
      dpop[0] <= s3_x;
      drho[0] <= s3_rho;
      for (int k = 1; k < DL; k++) begin
        dpop[k] <= dpop[k-1];
        drho[k] <= drho[k-1];
      end
    end
  end

  // E1..E7: equilibrium and non-equilibrium parts
  lbmsv_pkg::word_t e1_x [8];
  lbmsv_pkg::word_t e1_vx2, e1_vy2, e1_vxpy, e1_vxmy, e1_lvx, e1_lvy;
  lbmsv_pkg::word_t e1_rp1, e1_rp2, e1_invsq, e1_cs2, e1_half;

  lbmsv_pkg::word_t e2_x [8];
  lbmsv_pkg::word_t e2_vsq, e2_sxpy, e2_sxmy, e2_lvxpy, e2_lvxmy, e2_lvx, e2_lvy;
  lbmsv_pkg::word_t e2_o1, e2_o2, e2_t3x, e2_t3y, e2_rp1, e2_rp2;
  lbmsv_pkg::word_t e2_cs18, e2_invsq, e2_half;

  lbmsv_pkg::word_t e3_x [8];
  lbmsv_pkg::word_t e3_dxpy, e3_dxmy, e3_dx, e3_dy;
  lbmsv_pkg::word_t e3_lvx, e3_lvy, e3_lvxpy, e3_lvxmy, e3_rp1, e3_rp2, e3_o1, e3_o2;
  lbmsv_pkg::word_t e3_cs18, e3_invsq, e3_half;

  lbmsv_pkg::word_t e4_x [8];
  lbmsv_pkg::word_t e4_mxpy, e4_mxmy, e4_mx, e4_my;
  lbmsv_pkg::word_t e4_lvx, e4_lvy, e4_lvxpy, e4_lvxmy, e4_rp1, e4_rp2, e4_o1, e4_o2;
  lbmsv_pkg::word_t e4_cs18, e4_invsq, e4_half;

  lbmsv_pkg::word_t e5_x [8];
  lbmsv_pkg::word_t e5_s [8];
  lbmsv_pkg::word_t e5_rp1, e5_rp2, e5_o1, e5_o2, e5_cs18, e5_invsq, e5_half;

  lbmsv_pkg::word_t e6_x [8];
  lbmsv_pkg::word_t e6_p [8];
  lbmsv_pkg::word_t e6_o1, e6_o2, e6_cs18, e6_invsq, e6_half;

  lbmsv_pkg::word_t e7_n [8];
  lbmsv_pkg::word_t e7_cs18, e7_invsq, e7_half;

  lbmsv_pkg::word_t qxpy, qxmy, qx, qy;
  assign qxpy = lbmsv_pkg::qadd(c0, e4_mxpy);
  assign qxmy = lbmsv_pkg::qadd(c0, e4_mxmy);
  assign qx = lbmsv_pkg::qadd(c0, e4_mx);
  assign qy = lbmsv_pkg::qadd(c0, e4_my);

  always_ff @(posedge clk) begin
    if (en) begin
      e1_x <= dpop[DL-1];
      e1_vx2 <= lbmsv_pkg::qmul(vx, vx);
      e1_vy2 <= lbmsv_pkg::qmul(vy, vy);
      e1_vxpy <= lbmsv_pkg::qadd(vx, vy);
      e1_vxmy <= lbmsv_pkg::qsub(vx, vy);
      e1_lvx <= lbmsv_pkg::qmul(lc, vx);
      e1_lvy <= lbmsv_pkg::qmul(lc, vy);
      e1_rp1 <= lbmsv_pkg::qmul(drho[DL-1], wa);
      e1_rp2 <= lbmsv_pkg::qmul(drho[DL-1], wd);
      e1_invsq <= lbmsv_pkg::qmul(inv, inv);
      e1_cs2 <= lbmsv_pkg::qmul(cs, cs);
      e1_half <= half;

      e2_x <= e1_x;
      e2_vsq <= lbmsv_pkg::qadd(e1_vx2, e1_vy2);
      e2_sxpy <= lbmsv_pkg::qmul(e1_vxpy, e1_vxpy);
      e2_sxmy <= lbmsv_pkg::qmul(e1_vxmy, e1_vxmy);
      e2_lvxpy <= lbmsv_pkg::qmul(lc, e1_vxpy);
      e2_lvxmy <= lbmsv_pkg::qmul(lc, e1_vxmy);
      e2_lvx <= e1_lvx;
      e2_lvy <= e1_lvy;
      e2_o1 <= shift_mode ? lbmsv_pkg::qsub(e1_rp1, wa) : '0;
      e2_o2 <= shift_mode ? lbmsv_pkg::qsub(e1_rp2, wd) : '0;
      e2_t3x <= lbmsv_pkg::mul3(e1_vx2);
      e2_t3y <= lbmsv_pkg::mul3(e1_vy2);
      e2_rp1 <= e1_rp1;
      e2_rp2 <= e1_rp2;
      e2_cs18 <= lbmsv_pkg::mul18(e1_cs2);
      e2_invsq <= e1_invsq;
      e2_half <= e1_half;

      e3_x <= e2_x;
      e3_dxpy <= lbmsv_pkg::qsub(lbmsv_pkg::mul3(e2_sxpy), e2_vsq);
      e3_dxmy <= lbmsv_pkg::qsub(lbmsv_pkg::mul3(e2_sxmy), e2_vsq);
      e3_dx <= lbmsv_pkg::qsub(e2_t3x, e2_vsq);
      e3_dy <= lbmsv_pkg::qsub(e2_t3y, e2_vsq);
      e3_lvx <= e2_lvx;
      e3_lvy <= e2_lvy;
      e3_lvxpy <= e2_lvxpy;
      e3_lvxmy <= e2_lvxmy;
      e3_rp1 <= e2_rp1;
      e3_rp2 <= e2_rp2;
      e3_o1 <= e2_o1;
      e3_o2 <= e2_o2;
      e3_cs18 <= e2_cs18;
      e3_invsq <= e2_invsq;
      e3_half <= e2_half;

      e4_x <= e3_x;
      e4_mxpy <= lbmsv_pkg::qmul(qc, e3_dxpy);
      e4_mxmy <= lbmsv_pkg::qmul(qc, e3_dxmy);
      e4_mx <= lbmsv_pkg::qmul(qc, e3_dx);
      e4_my <= lbmsv_pkg::qmul(qc, e3_dy);
      e4_lvx <= e3_lvx;
      e4_lvy <= e3_lvy;
      e4_lvxpy <= e3_lvxpy;
      e4_lvxmy <= e3_lvxmy;
      e4_rp1 <= e3_rp1;
      e4_rp2 <= e3_rp2;
      e4_o1 <= e3_o1;
      e4_o2 <= e3_o2;
      e4_cs18 <= e3_cs18;
      e4_invsq <= e3_invsq;
      e4_half <= e3_half;

      e5_x <= e4_x;
      e5_s[0] <= lbmsv_pkg::qadd(e4_lvxmy, qxmy);
      e5_s[1] <= lbmsv_pkg::qadd(e4_lvxpy, qxpy);
      e5_s[2] <= lbmsv_pkg::qadd(e4_lvx, qx);
      e5_s[3] <= lbmsv_pkg::qadd(e4_lvy, qy);
      e5_s[4] <= lbmsv_pkg::qsub(qxpy, e4_lvxpy);
      e5_s[5] <= lbmsv_pkg::qsub(qxmy, e4_lvxmy);
      e5_s[6] <= lbmsv_pkg::qsub(qx, e4_lvx);
      e5_s[7] <= lbmsv_pkg::qsub(qy, e4_lvy);
      e5_rp1 <= e4_rp1;
      e5_rp2 <= e4_rp2;
      e5_o1 <= e4_o1;
      e5_o2 <= e4_o2;
      e5_cs18 <= e4_cs18;
      e5_invsq <= e4_invsq;
      e5_half <= e4_half;

      e6_x <= e5_x;
      // diagonals scale by the diagonal weight, axes by the axis weight
      e6_p[0] <= lbmsv_pkg::qmul(e5_rp2, e5_s[0]);
      e6_p[1] <= lbmsv_pkg::qmul(e5_rp2, e5_s[1]);
      e6_p[2] <= lbmsv_pkg::qmul(e5_rp1, e5_s[2]);
      e6_p[3] <= lbmsv_pkg::qmul(e5_rp1, e5_s[3]);
      e6_p[4] <= lbmsv_pkg::qmul(e5_rp2, e5_s[4]);
      e6_p[5] <= lbmsv_pkg::qmul(e5_rp2, e5_s[5]);
      e6_p[6] <= lbmsv_pkg::qmul(e5_rp1, e5_s[6]);
      e6_p[7] <= lbmsv_pkg::qmul(e5_rp1, e5_s[7]);
      e6_o1 <= e5_o1;
      e6_o2 <= e5_o2;
      e6_cs18 <= e5_cs18;
      e6_invsq <= e5_invsq;
      e6_half <= e5_half;

      e7_n[0] <= lbmsv_pkg::qsub(e6_x[0], lbmsv_pkg::qadd(e6_p[0], e6_o2));
      e7_n[1] <= lbmsv_pkg::qsub(e6_x[1], lbmsv_pkg::qadd(e6_p[1], e6_o2));
      e7_n[2] <= lbmsv_pkg::qsub(e6_x[2], lbmsv_pkg::qadd(e6_p[2], e6_o1));
      e7_n[3] <= lbmsv_pkg::qsub(e6_x[3], lbmsv_pkg::qadd(e6_p[3], e6_o1));
      e7_n[4] <= lbmsv_pkg::qsub(e6_x[4], lbmsv_pkg::qadd(e6_p[4], e6_o2));
      e7_n[5] <= lbmsv_pkg::qsub(e6_x[5], lbmsv_pkg::qadd(e6_p[5], e6_o2));
      e7_n[6] <= lbmsv_pkg::qsub(e6_x[6], lbmsv_pkg::qadd(e6_p[6], e6_o1));
      e7_n[7] <= lbmsv_pkg::qsub(e6_x[7], lbmsv_pkg::qadd(e6_p[7], e6_o1));
      e7_cs18 <= e6_cs18;
      e7_invsq <= e6_invsq;
      e7_half <= e6_half;
    end
  end

  // E8..E12: flux tensor and its squared norm
  lbmsv_pkg::word_t e8_xa, e8_xb, e8_ya, e8_yb, e8_xy, e8_n12;
  lbmsv_pkg::word_t e8_cs18, e8_invsq, e8_half;
  lbmsv_pkg::word_t e9_pxx, e9_pyy, e9_pxy, e9_cs18, e9_invsq, e9_half;
  lbmsv_pkg::word_t e10_mxx, e10_mxy, e10_myy, e10_cs18, e10_invsq, e10_half;
  lbmsv_pkg::word_t e11_sq, e11_myy, e11_cs18, e11_invsq, e11_half;
  lbmsv_pkg::word_t e12_parg, e12_cs18, e12_invsq, e12_half;

  always_ff @(posedge clk) begin
    if (en) begin
      e8_xa <= lbmsv_pkg::qadd(lbmsv_pkg::qadd(e7_n[0], e7_n[1]),
                               lbmsv_pkg::qadd(e7_n[2], e7_n[4]));
      e8_xb <= lbmsv_pkg::qadd(e7_n[5], e7_n[6]);
      e8_ya <= lbmsv_pkg::qadd(lbmsv_pkg::qadd(e7_n[0], e7_n[1]),
                               lbmsv_pkg::qadd(e7_n[3], e7_n[4]));
      e8_yb <= lbmsv_pkg::qadd(e7_n[5], e7_n[7]);
      e8_xy <= lbmsv_pkg::qsub(lbmsv_pkg::qadd(e7_n[1], e7_n[4]), e7_n[0]);
      e8_n12 <= e7_n[5];
      e8_cs18 <= e7_cs18;
      e8_invsq <= e7_invsq;
      e8_half <= e7_half;

      e9_pxx <= lbmsv_pkg::qadd(e8_xa, e8_xb);
      e9_pyy <= lbmsv_pkg::qadd(e8_ya, e8_yb);
      e9_pxy <= lbmsv_pkg::qsub(e8_xy, e8_n12);
      e9_cs18 <= e8_cs18;
      e9_invsq <= e8_invsq;
      e9_half <= e8_half;

      e10_mxx <= lbmsv_pkg::qmul(e9_pxx, e9_pxx);
      e10_mxy <= lbmsv_pkg::qmul(e9_pxy, e9_pxy);
      e10_myy <= lbmsv_pkg::qmul(e9_pyy, e9_pyy);
      e10_cs18 <= e9_cs18;
      e10_invsq <= e9_invsq;
      e10_half <= e9_half;

      e11_sq <= lbmsv_pkg::qadd(e10_mxx, lbmsv_pkg::mul2(e10_mxy));
      e11_myy <= e10_myy;
      e11_cs18 <= e10_cs18;
      e11_invsq <= e10_invsq;
      e11_half <= e10_half;

      e12_parg <= lbmsv_pkg::qadd(e11_sq, e11_myy);
      e12_cs18 <= e11_cs18;
      e12_invsq <= e11_invsq;
      e12_half <= e11_half;
    end
  end

  // flux norm
  lbmsv_pkg::word_t ptot;
  lbmsv_sqrt u_sqrt_flux (.clk(clk), .en(en), .arg(e12_parg), .root(ptot));

  lbmsv_pkg::word_t dcs18 [SL];
  lbmsv_pkg::word_t dinvsq [SL];
  lbmsv_pkg::word_t dhalf1 [SL];

  lbmsv_pkg::word_t f1_m, f1_invsq, f1_half;
  lbmsv_pkg::word_t f2_arg, f2_half;

  always_ff @(posedge clk) begin
    if (en) begin
      dcs18[0] <= e12_cs18;
      dinvsq[0] <= e12_invsq;
      dhalf1[0] <= e12_half;
      for (int k = 1; k < SL; k++) begin
        dcs18[k] <= dcs18[k-1];
        dinvsq[k] <= dinvsq[k-1];
        dhalf1[k] <= dhalf1[k-1];
      end

      f1_m <= lbmsv_pkg::qmul(dcs18[SL-1], ptot);
      f1_invsq <= dinvsq[SL-1];
      f1_half <= dhalf1[SL-1];

      f2_arg <= lbmsv_pkg::qadd(f1_m, f1_invsq);
      f2_half <= f1_half;
    end
  end

  // relaxation time root
  lbmsv_pkg::word_t troot;
  lbmsv_sqrt u_sqrt_tau (.clk(clk), .en(en), .arg(f2_arg), .root(troot));

  lbmsv_pkg::word_t dhalf2 [SL];
  lbmsv_pkg::word_t g1_ts, g2_v, g4_visc;
  logic g3_neg;
  logic [63:0] g3_prod;

  always_ff @(posedge clk) begin
    if (en) begin
      dhalf2[0] <= f2_half;
      for (int k = 1; k < SL; k++) dhalf2[k] <= dhalf2[k-1];

      g1_ts <= lbmsv_pkg::qadd(dhalf2[SL-1], troot >>> 1);
      g2_v <= lbmsv_pkg::qsub(lbmsv_pkg::mul2(g1_ts), lbmsv_pkg::ONE);

      // divide by 6 toward zero: magnitude times reciprocal
      g3_neg <= g2_v[31];
      g3_prod <= 64'(lbmsv_pkg::mag(g2_v)) * 64'(lbmsv_pkg::RECIP6);

      if (g3_neg) g4_visc <= -lbmsv_pkg::word_t'({2'b0, g3_prod[63:34]});
      else g4_visc <= lbmsv_pkg::word_t'({2'b0, g3_prod[63:34]});
    end
  end

  assign visc_ch.valid = vld[PD-1];
  assign visc_ch.viscosity = g4_visc;

  a_reset_empty: assert property (@(posedge clk) rst |=> !visc_ch.valid)
    else $error("result valid right after reset");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    (visc_ch.valid && !visc_ch.ready) |=> $stable(vld))
    else $error("pipeline moved during output stall");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    (pop_ch.valid && pop_ch.ready) |=> vld[0])
    else $error("accepted cell lost at pipeline entry");

endmodule

// ===== tb/lbmsv_checker.sv =====
`timescale 1ns / 100ps

module lbmsv_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wen,
  input  logic [2:0]   cfg_addr,
  input  logic [30:0]  cfg_wdata,
  lbmsv_pop_if         pop_ch,
  lbmsv_visc_if        visc_ch,
  output int           errors,
  output int           pending
);

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;

  logic [30:0] cfg_shadow [8];
  lbmsv_pkg::word_t visc_q[$];

  function automatic logic [30:0] reg_mask(logic [2:0] idx);
    case (idx)
      lbmsv_pkg::REG_SHIFT_MODE: return 31'h1;
      lbmsv_pkg::REG_QUAD_COEF, lbmsv_pkg::REG_LIN_COEF: return 31'h7FFF_FFFF;
      lbmsv_pkg::REG_RELAX_RATE: return 31'h3FF_FFFF;
      default: return 31'h1FF_FFFF;
    endcase
  endfunction

  function automatic longint sat(longint x);
    if (x > VMAX) return VMAX;
    if (x < VMIN) return VMIN;
    return x;
  endfunction

  function automatic longint sadd(longint a, longint b);
    return sat(a + b);
  endfunction

  function automatic longint ssub(longint a, longint b);
    return sat(a - b);
  endfunction

  function automatic longint signed_mag(longint unsigned m, bit neg);
    if (neg) return (m >= 64'd2147483648) ? VMIN : -longint'(m);
    return (m > 64'd2147483647) ? VMAX : longint'(m);
  endfunction

  function automatic longint absv(longint x);
    return x < 0 ? -x : x;
  endfunction

  // frac: shift the product down by 24 (fixed-point) or not (integer scale)
  function automatic longint fmul(longint a, longint b, bit frac);
    longint unsigned m;
    m = longint'(absv(a)) * longint'(absv(b));
    if (frac) m = m >> lbmsv_pkg::FRAC;
    return signed_mag(m, (a < 0) != (b < 0));
  endfunction

  function automatic longint fdiv(longint n, longint d);
    longint unsigned q;
    if (d == 0) return n > 0 ? VMAX : (n < 0 ? VMIN : 0);
    q = (longint'(absv(n)) << lbmsv_pkg::FRAC) / absv(d);
    return signed_mag(q, (n < 0) != (d < 0));
  endfunction

  function automatic longint fsqrt(longint x);
    longint unsigned n, r, t;
    if (x <= 0) return 0;
    n = longint'(x) << lbmsv_pkg::FRAC;
    r = 0;
    for (int b = 28; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return sat(longint'(r));
  endfunction

  function automatic longint eq_quad(longint c0, longint qc, longint s2, longint vsq);
    return sadd(c0, fmul(qc, ssub(fmul(s2, 3, 0), vsq), 1));
  endfunction

  function automatic lbmsv_pkg::word_t predict_visc(lbmsv_pkg::word_t p [9]);
    bit sh;
    longint one, qc, lc, wa, wd, om, cs;
    longint se, ne, e, n, sw, nw, w, s, rest;
    longint rho, mx, my, vx, vy, vx2, vy2, vsq, vxpy, vxmy, c0;
    longint qxpy, qxmy, qx, qy, lvx, lvy, lvxpy, lvxmy, rp1, rp2, o1, o2;
    longint n01, n03, n05, n08, n10, n12, n14, n17, pxx, pyy, pxy, ptot;
    longint inv, half, arg, ts, v;
    sh = cfg_shadow[lbmsv_pkg::REG_SHIFT_MODE][0];
    one = lbmsv_pkg::ONE;
    qc = cfg_shadow[lbmsv_pkg::REG_QUAD_COEF];
    lc = cfg_shadow[lbmsv_pkg::REG_LIN_COEF];
    wa = cfg_shadow[lbmsv_pkg::REG_WEIGHT_AXIS];
    wd = cfg_shadow[lbmsv_pkg::REG_WEIGHT_DIAG];
    om = cfg_shadow[lbmsv_pkg::REG_RELAX_RATE];
    cs = cfg_shadow[lbmsv_pkg::REG_SMAG_CONST];
    se = p[0]; ne = p[1]; e = p[2]; n = p[3]; sw = p[4];
    nw = p[5]; w = p[6]; s = p[7]; rest = p[8];

    rho = sadd(sadd(sadd(sadd(se, ne), sadd(e, n)), sadd(sadd(sw, nw), sadd(w, s))), rest);
    rho = sadd(rho, sh ? one : 0);
    mx = ssub(ssub(ssub(sadd(sadd(se, ne), e), sw), nw), w);
    my = ssub(ssub(ssub(sadd(sadd(ne, n), nw), se), sw), s);
    vx = fdiv(mx, rho);
    vy = fdiv(my, rho);
    vx2 = fmul(vx, vx, 1);
    vy2 = fmul(vy, vy, 1);
    vsq = sadd(vx2, vy2);
    vxpy = sadd(vx, vy);
    vxmy = ssub(vx, vy);
    c0 = sh ? 0 : one;
    qxpy = eq_quad(c0, qc, fmul(vxpy, vxpy, 1), vsq);
    qxmy = eq_quad(c0, qc, fmul(vxmy, vxmy, 1), vsq);
    qx = eq_quad(c0, qc, vx2, vsq);
    qy = eq_quad(c0, qc, vy2, vsq);
    lvx = fmul(lc, vx, 1);
    lvy = fmul(lc, vy, 1);
    lvxpy = fmul(lc, vxpy, 1);
    lvxmy = fmul(lc, vxmy, 1);
    rp1 = fmul(rho, wa, 1);
    rp2 = fmul(rho, wd, 1);
    o1 = sh ? ssub(rp1, wa) : 0;
    o2 = sh ? ssub(rp2, wd) : 0;

    n01 = ssub(se, sadd(fmul(rp2, sadd(lvxmy, qxmy), 1), o2));
    n03 = ssub(ne, sadd(fmul(rp2, sadd(lvxpy, qxpy), 1), o2));
    n05 = ssub(e, sadd(fmul(rp1, sadd(lvx, qx), 1), o1));
    n08 = ssub(n, sadd(fmul(rp1, sadd(lvy, qy), 1), o1));
    n10 = ssub(sw, sadd(fmul(rp2, ssub(qxpy, lvxpy), 1), o2));
    n12 = ssub(nw, sadd(fmul(rp2, ssub(qxmy, lvxmy), 1), o2));
    n14 = ssub(w, sadd(fmul(rp1, ssub(qx, lvx), 1), o1));
    n17 = ssub(s, sadd(fmul(rp1, ssub(qy, lvy), 1), o1));

    pxx = sadd(sadd(sadd(n01, n03), sadd(n05, n10)), sadd(n12, n14));
    pyy = sadd(sadd(sadd(n01, n03), sadd(n08, n10)), sadd(n12, n17));
    pxy = ssub(ssub(sadd(n03, n10), n01), n12);
    ptot = fsqrt(sadd(sadd(fmul(pxx, pxx, 1), fmul(fmul(pxy, pxy, 1), 2, 0)),
                      fmul(pyy, pyy, 1)));

    inv = fdiv(one, om);
    half = fdiv(one, fmul(om, 2, 0));
    arg = sadd(fmul(fmul(fmul(cs, cs, 1), 18, 0), ptot, 1), fmul(inv, inv, 1));
    ts = sadd(half, fsqrt(arg) / 2);
    v = ssub(fmul(ts, 2, 0), one) / 6;
    return lbmsv_pkg::word_t'(sat(v));
  endfunction

  always @(posedge clk) begin
    lbmsv_pkg::word_t pops [9];
    lbmsv_pkg::word_t exp_v;
    if (rst) begin
      cfg_shadow[0] <= 31'd1;
      cfg_shadow[1] <= 31'd75497472;
      cfg_shadow[2] <= 31'd50331648;
      cfg_shadow[3] <= 31'd7456540;
      cfg_shadow[4] <= 31'd1864135;
      cfg_shadow[5] <= 31'd466034;
      cfg_shadow[6] <= 31'd16777216;
      cfg_shadow[7] <= 31'd2516582;
      visc_q.delete();
    end else begin
      if (cfg_wen) cfg_shadow[cfg_addr] <= cfg_wdata & reg_mask(cfg_addr);
      if (pop_ch.valid && pop_ch.ready) begin
        pops[0] = pop_ch.pop_se; pops[1] = pop_ch.pop_ne; pops[2] = pop_ch.pop_e;
        pops[3] = pop_ch.pop_n; pops[4] = pop_ch.pop_sw; pops[5] = pop_ch.pop_nw;
        pops[6] = pop_ch.pop_w; pops[7] = pop_ch.pop_s; pops[8] = pop_ch.pop_rest;
        visc_q.push_back(predict_visc(pops));
      end
      if (visc_ch.valid && visc_ch.ready) begin
        if (visc_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected viscosity transfer, actual %h", $time,
                   visc_ch.viscosity);
        end else begin
          exp_v = visc_q.pop_front();
          if (visc_ch.viscosity !== exp_v) begin
            errors++;
            $display("%0t: viscosity mismatch, expected %h actual %h", $time, exp_v,
                     visc_ch.viscosity);
          end
        end
      end
    end
    pending <= visc_q.size();
  end
endmodule

// ===== tb/tb_lbm_smagorinsky_viscosity_core.sv =====
`timescale 1ns / 100ps

module tb_lbm_smagorinsky_viscosity_core;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [2:0]  cfg_addr = lbmsv_pkg::REG_SHIFT_MODE;
  logic [30:0] cfg_wdata = '0;
  int          errors, pending;
  bit          no_stall = 1'b0;
  bit          no_gap = 1'b0;

  lbmsv_pop_if  pop_ch ();
  lbmsv_visc_if visc_ch ();

  lbm_smagorinsky_viscosity_core dut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .pop_ch(pop_ch), .visc_ch(visc_ch)
  );

  lbmsv_checker u_check (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .pop_ch(pop_ch), .visc_ch(visc_ch),
    .errors(errors), .pending(pending)
  );

  always #1 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  initial begin
    int g;
    visc_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      g = no_stall ? 0 : gap_len();
      if (g > 0) begin
        visc_ch.ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      visc_ch.ready <= 1'b1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  // called at a falling edge; leaves at a falling edge
  task automatic send_cell(lbmsv_pkg::word_t p [9]);
    int g;
    pop_ch.valid <= 1'b1;
    pop_ch.pop_se <= p[0]; pop_ch.pop_ne <= p[1]; pop_ch.pop_e <= p[2];
    pop_ch.pop_n <= p[3]; pop_ch.pop_sw <= p[4]; pop_ch.pop_nw <= p[5];
    pop_ch.pop_w <= p[6]; pop_ch.pop_s <= p[7]; pop_ch.pop_rest <= p[8];
    do @(posedge clk); while (!pop_ch.ready);
    @(negedge clk);
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      pop_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic send_fill(lbmsv_pkg::word_t v);
    lbmsv_pkg::word_t p [9];
    foreach (p[i]) p[i] = v;
    send_cell(p);
  endtask

  task automatic send_noise();
    lbmsv_pkg::word_t p [9];
    foreach (p[i]) p[i] = lbmsv_pkg::word_t'($urandom);
    send_cell(p);
  endtask

  // near-equilibrium cell with small velocity and shear noise
  task automatic send_flow(bit shifted);
    real w [9], ex [9], ey [9], rho, ux, uy, f, amp;
    lbmsv_pkg::word_t p [9];
    w = '{1.0/36, 1.0/36, 1.0/9, 1.0/9, 1.0/36, 1.0/36, 1.0/9, 1.0/9, 4.0/9};
    ex = '{1, 1, 1, 0, -1, -1, -1, 0, 0};
    ey = '{-1, 1, 0, 1, -1, 1, 0, -1, 0};
    rho = 0.5 + $urandom_range(1000) / 1000.0;
    ux = ($urandom_range(400) - 200.0) / 1000.0;
    uy = ($urandom_range(400) - 200.0) / 1000.0;
    amp = ($urandom_range(3) == 0) ? 0.2 : 0.01;
    foreach (p[i]) begin
      f = w[i] * rho * (1.0 + 3.0 * (ex[i] * ux + ey[i] * uy))
          + amp * ($urandom_range(2000) - 1000.0) / 1000.0;
      if (shifted) f = f - w[i];
      p[i] = lbmsv_pkg::word_t'($rtoi(f * 16777216.0));
    end
    send_cell(p);
  endtask

  // called at a falling edge right after the last cell
  task automatic drain();
    pop_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (lbmsv_pkg::PIPE_DEPTH + 10) @(negedge clk);
  endtask

  task automatic random_phase(int n, bit shifted);
    for (int k = 0; k < n; k++) begin
      if (k % 70 == 0) begin
        no_gap = ($urandom_range(3) == 0);
        no_stall = ($urandom_range(3) == 0);
      end
      if ($urandom_range(9) < 8) send_flow(shifted);
      else send_noise();
    end
    no_gap = 1'b0;
    no_stall = 1'b0;
  endtask

  initial begin
    lbmsv_pkg::word_t p [9];
    pop_ch.valid = 1'b0;
    pop_ch.pop_se = '0; pop_ch.pop_ne = '0; pop_ch.pop_e = '0;
    pop_ch.pop_n = '0; pop_ch.pop_sw = '0; pop_ch.pop_nw = '0;
    pop_ch.pop_w = '0; pop_ch.pop_s = '0; pop_ch.pop_rest = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults: field extremes, density of zero in shift mode
    @(negedge clk);
    send_fill(lbmsv_pkg::WMAX);
    send_fill(lbmsv_pkg::WMIN);
    send_fill('0);
    send_fill(32'sh0000_0001);
    send_fill(-32'sh0000_0001);
    foreach (p[i]) p[i] = '0;
    p[8] = -lbmsv_pkg::ONE;
    send_cell(p);
    foreach (p[i]) p[i] = (i % 2) ? lbmsv_pkg::WMAX : lbmsv_pkg::WMIN;
    send_cell(p);
    foreach (p[i]) p[i] = (i % 2) ? lbmsv_pkg::WMIN : lbmsv_pkg::WMAX;
    send_cell(p);
    for (int k = 0; k < 6; k++) send_flow(1'b1);
    random_phase(180, 1'b1);
    drain();

    // absolute populations, zero density and random registers
    write_reg(lbmsv_pkg::REG_SHIFT_MODE, 31'd0);
    write_reg(lbmsv_pkg::REG_QUAD_COEF, 31'(75497472 + $urandom_range(1 << 20)));
    write_reg(lbmsv_pkg::REG_LIN_COEF, 31'(50331648 - $urandom_range(1 << 20)));
    write_reg(lbmsv_pkg::REG_WEIGHT_REST, 31'($urandom_range(16777216)));
    write_reg(lbmsv_pkg::REG_WEIGHT_AXIS, 31'(1864135 + $urandom_range(4096)));
    write_reg(lbmsv_pkg::REG_WEIGHT_DIAG, 31'(466034 - $urandom_range(4096)));
    write_reg(lbmsv_pkg::REG_RELAX_RATE, 31'($urandom_range(33554432, 8388608)));
    write_reg(lbmsv_pkg::REG_SMAG_CONST, 31'($urandom_range(16777216)));
    @(negedge clk);
    send_fill('0);
    foreach (p[i]) p[i] = '0;
    p[2] = lbmsv_pkg::ONE;
    p[6] = -lbmsv_pkg::ONE;
    send_cell(p);
    random_phase(220, 1'b0);
    drain();

    // upper register extremes
    write_reg(lbmsv_pkg::REG_SHIFT_MODE, 31'd1);
    write_reg(lbmsv_pkg::REG_QUAD_COEF, 31'h7FFF_FFFF);
    write_reg(lbmsv_pkg::REG_LIN_COEF, 31'h7FFF_FFFF);
    write_reg(lbmsv_pkg::REG_WEIGHT_REST, 31'd16777216);
    write_reg(lbmsv_pkg::REG_WEIGHT_AXIS, 31'd16777216);
    write_reg(lbmsv_pkg::REG_WEIGHT_DIAG, 31'd16777216);
    write_reg(lbmsv_pkg::REG_RELAX_RATE, 31'd33554432);
    write_reg(lbmsv_pkg::REG_SMAG_CONST, 31'd16777216);
    @(negedge clk);
    send_fill(lbmsv_pkg::WMAX);
    send_fill(lbmsv_pkg::WMIN);
    random_phase(200, 1'b1);
    drain();

    // lower register extremes; omega of one LSB saturates the relaxation time
    write_reg(lbmsv_pkg::REG_SHIFT_MODE, 31'd0);
    write_reg(lbmsv_pkg::REG_QUAD_COEF, 31'd0);
    write_reg(lbmsv_pkg::REG_LIN_COEF, 31'd0);
    write_reg(lbmsv_pkg::REG_WEIGHT_REST, 31'd0);
    write_reg(lbmsv_pkg::REG_WEIGHT_AXIS, 31'd0);
    write_reg(lbmsv_pkg::REG_WEIGHT_DIAG, 31'd0);
    write_reg(lbmsv_pkg::REG_RELAX_RATE, 31'd1);
    write_reg(lbmsv_pkg::REG_SMAG_CONST, 31'd0);
    @(negedge clk);
    send_fill('0);
    random_phase(100, 1'b0);
    drain();

    // back to defaults, apart from the rest weight and a random relaxation rate, for a final stretch
    write_reg(lbmsv_pkg::REG_SHIFT_MODE, 31'd1);
    write_reg(lbmsv_pkg::REG_QUAD_COEF, 31'd75497472);
    write_reg(lbmsv_pkg::REG_LIN_COEF, 31'd50331648);
    write_reg(lbmsv_pkg::REG_WEIGHT_AXIS, 31'd1864135);
    write_reg(lbmsv_pkg::REG_WEIGHT_DIAG, 31'd466034);
    write_reg(lbmsv_pkg::REG_RELAX_RATE, 31'($urandom_range(33554432, 1)));
    write_reg(lbmsv_pkg::REG_SMAG_CONST, 31'd2516582);
    @(negedge clk);
    random_phase(130, 1'b1);
    drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
